// File: design/compacting_array_list_core_defines.svh
// Assertion macros used by the checker file design/cal_checker.sv.
`ifndef COMPACTING_ARRAY_LIST_CORE_DEFINES_SVH
`define COMPACTING_ARRAY_LIST_CORE_DEFINES_SVH

// Implication in the same cycle.
`define CAL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define CAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/cal_pkg.sv
package cal_pkg;

    localparam int CAP_W         = 5;
    localparam int COUNT_W       = 5;
    localparam int VALUE_W       = 32;
    localparam int DEPTH_DEF     = 16;
    localparam int ELEM_BITS_DEF = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [VALUE_W-1:0] element_value;
    } cal_in_t;

    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] entry_count;
    } cal_out_t;

endpackage

// File: design/cal_ram.sv
module cal_ram
    import cal_pkg::*;
#(
    parameter int WIDTH = ELEM_BITS_DEF,
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/compacting_array_list_core.sv
// Ordered list of up to DEPTH elements with append and remove-all.
// Input channel in_valid / in_stall / in_data: operation add (append) or
// remove (delete every equal element and close the gaps). One result per
// item on out_valid / out_stall / out_data: ok flag and the entry count.
// Configuration channel cfg_valid / cfg_ready / cfg_data writes the capacity
// in use; cfg_ready is always high, write only while no item is in flight.
// An add or a remove of an empty list goes from ST_IDLE to ST_DONE; a remove
// of a non-empty list first passes ST_SCAN, which reads and rewrites the
// element RAM one entry per cycle; ST_DONE waits for a free output register.
// One item is in work at a time; in_stall is high from acceptance until the
// result moves into the output register; a new item waits for that move.
// When the receiver stalls, the result stays in the output register and
// the block may accept and finish one more item, which then waits until
// the output register frees.
// Reset clears the list to empty, capacity to 16 and drops any pending
// result. The element RAM is not cleared.
module compacting_array_list_core
    import cal_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int ELEM_BITS = ELEM_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  cal_in_t          in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output cal_out_t         out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        rd_reg, rd_next;
    logic [CW-1:0]        wr_reg, wr_next;
    logic                 pend_reg, pend_next;
    logic [CAP_W-1:0]     cap_reg;
    logic [ELEM_BITS-1:0] key_reg, key_next;
    logic                 ok_reg, ok_next;
    logic                 out_valid_reg, out_valid_next;
    cal_out_t             out_data_reg, out_data_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [ELEM_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [ELEM_BITS-1:0] ram_rdata;

    logic [CMPW-1:0]      cap_eff;
    logic                 full;
    logic                 in_accept;
    logic                 issue;

    cal_ram #(
        .WIDTH(ELEM_BITS),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign cap_eff   = (CMPW'(cap_reg) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(cap_reg);
    assign full      = (CMPW'(count_reg) >= cap_eff);
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign issue     = (rd_reg < count_reg);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        pend_next      = pend_reg;
        key_next       = key_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = wr_reg[AW-1:0];
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = rd_reg[AW-1:0];

        // drop a taken result
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    key_next = ELEM_BITS'(in_data.element_value);
                    if (in_data.operation == OP_ADD)
                    begin
                        state_next = ST_DONE;
                        if (!full)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[AW-1:0];
                            ram_wdata  = ELEM_BITS'(in_data.element_value);
                            count_next = count_reg + CW'(1);
                            ok_next    = 1'b1;
                        end
                        else
                        begin
                            ok_next = 1'b0;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        ok_next    = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_next    = '0;
                        wr_next    = '0;
                        pend_next  = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // read one entry, keep the previous one if it does not match
                ram_re    = issue;
                pend_next = issue;
                if (issue)
                begin
                    rd_next = rd_reg + CW'(1);
                end
                if (pend_reg && (ram_rdata != key_reg))
                begin
                    ram_we  = 1'b1;
                    wr_next = wr_reg + CW'(1);
                end
                if (!issue && !pend_reg)
                begin
                    count_next = wr_reg;
                    ok_next    = (wr_reg != count_reg);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.ok          = ok_reg;
                    out_data_next.entry_count = COUNT_W'(count_reg);
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= CAP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        ok_reg       <= ok_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: design/cal_checker.sv
`include "compacting_array_list_core_defines.svh"

module cal_checker
    import cal_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input cal_out_t out_data
);

    `CAL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted a second item back to back")
    `CAL_ASSERT_NOW(a_count_bound, out_valid, 32'(out_data.entry_count) <= DEPTH, "entry count above depth")
    `CAL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind compacting_array_list_core cal_checker #(.DEPTH(DEPTH)) u_cal_checker (.*);

// File: verif/compacting_array_list_checker.sv
module compacting_array_list_checker
    import cal_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  cal_in_t          in_data,
    input  logic             out_valid,
    input  logic             out_stall,
    input  cal_out_t         out_data,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data,
    output int               mismatch_count,
    output int               outstanding
);

    logic [VALUE_W-1:0] list_mem [DEPTH];
    int unsigned        list_len;
    logic [CAP_W-1:0]   capacity;
    cal_out_t           pending_results [$];

    function automatic cal_out_t apply_list_op(input cal_in_t op_item);
        int unsigned limit;
        int unsigned kept;
        cal_out_t    res;
        limit  = (capacity > DEPTH) ? DEPTH : capacity;
        res.ok = 1'b0;
        if (op_item.operation == OP_ADD) begin
            if (list_len < limit) begin
                list_mem[list_len] = op_item.element_value;
                list_len++;
                res.ok = 1'b1;
            end
        end
        else if (list_len != 0) begin
            kept = 0;
            for (int i = 0; i < list_len; i++) begin
                if (list_mem[i] !== op_item.element_value) begin
                    list_mem[kept] = list_mem[i];
                    kept++;
                end
            end
            res.ok   = (kept != list_len);
            list_len = kept;
        end
        res.entry_count = list_len[COUNT_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        cal_out_t want;
        int       errs;
        errs = 0;
        if (!rst_n)
        begin
            list_len = 0;
            capacity = CAP_RESET;
            pending_results.delete();
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected transaction: ok %0d, entry_count %0d",
                           out_data.ok, out_data.entry_count);
                    errs++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.ok !== want.ok)
                    begin
                        $error("ok mismatch: expected %0d, actual %0d",
                               want.ok, out_data.ok);
                        errs++;
                    end
                    if (out_data.entry_count !== want.entry_count)
                    begin
                        $error("entry_count mismatch: expected %0d, actual %0d",
                               want.entry_count, out_data.entry_count);
                        errs++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                pending_results.push_back(apply_list_op(in_data));
            end
            mismatch_count <= mismatch_count + errs;
            outstanding    <= pending_results.size();
        end
    end

endmodule

// File: verif/compacting_array_list_core_test.sv
module compacting_array_list_core_test;
    import cal_pkg::*;

    localparam int TIMEOUT_CYCLES  = 600000;
    localparam int ITEMS_PER_PHASE = 117;
    localparam int HOLD_CYCLES     = 300;
    localparam int NUM_PHASES      = 9;
    localparam int POOL_SIZE       = 5;
    localparam logic [CAP_W-1:0] CAP_PLAN [NUM_PHASES] =
        '{5'd16, 5'd1, 5'd31, 5'd6, 5'd0, 5'd17, 5'd3, 5'd16, 5'd11};

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    cal_in_t          in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    cal_out_t         out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data  = '0;

    int mismatch_count;
    int outstanding;
    int send_idle_pct = 33;
    int stall_pct     = 48;
    int cycle_count   = 0;
    bit hold_req      = 1'b0;

    logic [VALUE_W-1:0] value_pool [POOL_SIZE];

    compacting_array_list_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    compacting_array_list_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // hold off for a long stretch on request, else stall at random
    initial
    begin : stall_gen
        bit hold_done;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_op(input logic op, input logic [VALUE_W-1:0] value);
        cal_in_t op_item;
        int      gap;
        op_item.operation     = op;
        op_item.element_value = value;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= op_item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain_list;
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain_list();
        repeat (6) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_op;
        logic               op;
        logic [VALUE_W-1:0] value;
        op = ($urandom_range(0, 99) < 55) ? OP_ADD : OP_REMOVE;
        if ($urandom_range(0, 99) < 85)
            value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            value = $urandom;
        send_op(op, value);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(OP_REMOVE, 32'h0000_0000);
        send_op(OP_ADD, 32'h0000_0000);
        send_op(OP_ADD, 32'hFFFF_FFFF);
        send_op(OP_ADD, 32'h0000_0000);
        send_op(OP_REMOVE, 32'hDEAD_BEEF);
        send_op(OP_REMOVE, 32'h0000_0000);
        repeat (15) send_op(OP_ADD, 32'hFFFF_FFFF);
        send_op(OP_ADD, 32'h0000_0000);
        send_op(OP_REMOVE, 32'hFFFF_FFFF);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            write_capacity(CAP_PLAN[phase]);
            case (phase / 3)
                0: begin send_idle_pct = 33; stall_pct = 48; end
                1: begin send_idle_pct = 48; stall_pct = 33; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            for (int i = 0; i < POOL_SIZE; i++)
                value_pool[i] = $urandom;
            value_pool[0] = phase[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
            if (phase == 7)
                hold_req = 1'b1;
            repeat (ITEMS_PER_PHASE) send_random_op();
        end

        drain_list();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
